/* src/ngt_pkg.sv */
// Shared types and constants for the noise grid texture generator.
// No dependencies; every other file imports this package.
package ngt_pkg;

  // Texture side length in pixels and derived position counter width.
  localparam int IMAGE_SIDE = 128;
  localparam int CNT_W      = $clog2(IMAGE_SIDE);
  localparam logic [CNT_W-1:0] SIDE_LAST = CNT_W'(IMAGE_SIDE - 1);

  // Generator and shading constants.
  localparam logic [31:0] LCG_MUL     = 32'd1103515245;
  localparam logic [31:0] LCG_ADD     = 32'd12345;
  localparam logic [14:0] LCG_OUT_MASK = 15'h7fff;
  localparam logic [9:0]  GRID_DARKEN = 10'd45;
  localparam logic [7:0]  CHANNEL_MAX = 8'd255;

  // Remainder unit: 16-bit dividend, two quotient bits per step.
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_RED        = 3'd0,
    REG_BASE_GREEN      = 3'd1,
    REG_BASE_BLUE       = 3'd2,
    REG_NOISE_AMPLITUDE = 3'd3,
    REG_GRID_PITCH      = 3'd4,
    REG_NOISE_SEED      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ngt_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic emit;
  } ngt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } ngt_stat_t;

endpackage

/* src/ngt_ctrl.sv */
// Sequencer for the noise grid texture generator: accept, remainder steps, emit.
// Depends on ngt_pkg.
module ngt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  ngt_pkg::ngt_stat_t stat,
  output ngt_pkg::ngt_cmd_t  cmd
);
  import ngt_pkg::*;

  ngt_state_t           state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next   = ST_DIV;
          div_cnt_next = '0;
        end
      end
      ST_DIV: begin
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_stall    = 1'b1;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_EMIT: cmd.emit = stat.out_free;
      default: req_stall = 1'b1;
    endcase
  end

endmodule

/* src/ngt_dp.sv */
// Datapath: configuration registers, generator word, raster counters,
// two-bit-per-step remainder unit and the pixel output register.
// Depends on ngt_pkg.
module ngt_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ngt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            restart,
  input  ngt_pkg::ngt_cmd_t               cmd,
  output ngt_pkg::ngt_stat_t              stat,
  output logic                            pix_valid,
  input  logic                            pix_stall,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic [6:0]                      column,
  output logic [6:0]                      row,
  output logic                            frame_last
);
  import ngt_pkg::*;

  logic [7:0]  base_red, base_green, base_blue;
  logic [6:0]  noise_amplitude;
  logic [7:0]  grid_pitch;
  logic [31:0] noise_seed;

  logic [31:0]      generator_word;
  logic [CNT_W-1:0] column_count, row_count;
  logic [7:0]       column_phase, row_phase;

  logic [15:0] dividend, dividend_next;
  logic [7:0]  rem, rem_next;
  logic [7:0]  span;

  logic [31:0] word_src, word_step;
  logic        col_end, row_end, last;
  logic [7:0]  col_phase_adv, row_phase_adv;
  logic        dark;
  logic signed [9:0] offset;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_red        <= '0;
      base_green      <= '0;
      base_blue       <= '0;
      noise_amplitude <= '0;
      grid_pitch      <= '0;
      noise_seed      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_RED:        base_red        <= cfg_data[7:0];
        REG_BASE_GREEN:      base_green      <= cfg_data[7:0];
        REG_BASE_BLUE:       base_blue       <= cfg_data[7:0];
        REG_NOISE_AMPLITUDE: noise_amplitude <= cfg_data[6:0];
        REG_GRID_PITCH:      grid_pitch      <= cfg_data[7:0];
        REG_NOISE_SEED:      noise_seed      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign span      = {noise_amplitude, 1'b1};
  assign word_src  = restart ? noise_seed : generator_word;
  assign word_step = word_src * LCG_MUL + LCG_ADD;

  function automatic logic [7:0] phase_adv(input logic [7:0] phase, input logic [7:0] pitch);
    logic [8:0] inc;
    inc = {1'b0, phase} + 9'd1;
    return (inc >= {1'b0, pitch}) ? 8'd0 : inc[7:0];
  endfunction

  assign col_end       = (column_count == SIDE_LAST);
  assign row_end       = (row_count == SIDE_LAST);
  assign last          = col_end && row_end;
  assign col_phase_adv = phase_adv(column_phase, grid_pitch);
  assign row_phase_adv = phase_adv(row_phase, grid_pitch);

  // Generator word and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      generator_word <= '0;
      column_count   <= '0;
      row_count      <= '0;
      column_phase   <= '0;
      row_phase      <= '0;
    end else if (cmd.accept) begin
      if (noise_amplitude != 7'd0) generator_word <= word_step;
      else                         generator_word <= word_src;
      if (restart) begin
        column_count <= '0;
        row_count    <= '0;
        column_phase <= '0;
        row_phase    <= '0;
      end
    end else if (cmd.emit) begin
      if (last) begin
        generator_word <= noise_seed;
        column_count   <= '0;
        row_count      <= '0;
        column_phase   <= '0;
        row_phase      <= '0;
      end else if (col_end) begin
        column_count <= '0;
        column_phase <= '0;
        row_count    <= row_count + 1'b1;
        row_phase    <= row_phase_adv;
      end else begin
        column_count <= column_count + 1'b1;
        column_phase <= col_phase_adv;
      end
    end
  end

  // Two restoring remainder steps per cycle
  always_comb begin
    logic [8:0] r1, r2;
    r1 = {rem, dividend[15]};
    if (r1 >= {1'b0, span}) r1 = r1 - {1'b0, span};
    r2 = {r1[7:0], dividend[14]};
    if (r2 >= {1'b0, span}) r2 = r2 - {1'b0, span};
    rem_next      = r2[7:0];
    dividend_next = {dividend[13:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dividend <= {1'b0, word_step[30:16] & LCG_OUT_MASK};
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend_next;
      rem      <= rem_next;
    end
  end

  assign dark   = (grid_pitch != 8'd0) && (column_phase < 8'd2 || row_phase < 8'd2);
  assign offset = $signed({2'b00, rem}) - $signed({3'b000, noise_amplitude})
                  - $signed(dark ? GRID_DARKEN : 10'd0);

  function automatic logic [7:0] clamp(input logic [7:0] base, input logic signed [9:0] off);
    logic signed [10:0] sum;
    sum = $signed({3'b000, base}) + 11'(off);
    if (sum < 0)                               return 8'd0;
    else if (sum > $signed({3'b000, CHANNEL_MAX})) return CHANNEL_MAX;
    else                                       return sum[7:0];
  endfunction

  // Output word register
  assign stat.out_free = !pix_valid || !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (cmd.emit) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red        <= clamp(base_red, offset);
      green      <= clamp(base_green, offset);
      blue       <= clamp(base_blue, offset);
      column     <= 7'(column_count);
      row        <= 7'(row_count);
      frame_last <= last;
    end
  end

endmodule

/* src/noise_grid_texture_generator_top.sv */
// Top level of the noise grid texture generator: controller plus datapath.
// Depends on ngt_pkg, ngt_ctrl and ngt_dp.
//
// Usage:
//   Each word on the request channel (req_valid/req_stall, field restart)
//   asks for the next pixel of a 128 x 128 texture in raster order. With
//   restart set, the generator word reloads from the seed and the pixel
//   position returns to (0,0) before that pixel is made.
//   Each request yields one word on the pixel channel (pix_valid/pix_stall):
//   red, green, blue, column, row and frame_last.
//   The generator multiply is done in the accepting cycle and loads the
//   remainder unit; the two-bit-per-cycle remainder unit then runs in
//   ST_DIV, and ST_EMIT forms and registers the pixel. One request is in
//   flight at a time and the next is accepted in the cycle after the
//   pixel is registered.
//   A finished pixel waits in the output register while the receiver
//   stalls; the next request is accepted meanwhile, and its pixel is held
//   back until the register frees.
//   Reset (rst, synchronous) clears all configuration registers, the
//   generator word and the raster position; no pixel is valid after it.
//   Configuration writes (cfg_write, cfg_index, cfg_data) are registered.
module noise_grid_texture_generator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ngt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          restart,
  output logic                          pix_valid,
  input  logic                          pix_stall,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic [6:0]                    column,
  output logic [6:0]                    row,
  output logic                          frame_last
);
  import ngt_pkg::*;

  ngt_cmd_t  cmd;
  ngt_stat_t stat;

  ngt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ngt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .restart    (restart),
    .cmd        (cmd),
    .stat       (stat),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .column     (column),
    .row        (row),
    .frame_last (frame_last)
  );

endmodule

/* verif/ngt_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the noise grid texture generator: mirrors the register file,
// predicts each pixel from its request and compares it on delivery.
// Depends on ngt_pkg for the register indexes and the texture side.
module ngt_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ngt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic                          restart,
  input  logic                          pix_valid,
  input  logic                          pix_stall,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic [6:0]                    column,
  input  logic [6:0]                    row,
  input  logic                          frame_last,
  output int                            mismatches,
  output int                            pixels_pending,
  output int                            pixels_checked,
  output int                            frames_seen
);
  import ngt_pkg::*;

  localparam logic [31:0] LCG_MULT  = 32'd1103515245;
  localparam logic [31:0] LCG_INCR  = 32'd12345;
  localparam int          GRID_DROP = 45;
  localparam int          PRINT_CAP = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] column;
    logic [6:0] row;
    logic       frame_last;
  } pixel_t;

  // Mirrored registers.
  logic [7:0]  base_r, base_g, base_b;
  logic [6:0]  amplitude;
  logic [7:0]  pitch;
  logic [31:0] seed;

  // Mirrored raster and generator state.
  logic [31:0] lcg_word;
  int          col_pos, row_pos;
  logic [7:0]  col_phase, row_phase;

  pixel_t pixels_due[$];

  function automatic logic [7:0] saturate(int level);
    if (level < 0) return 8'd0;
    if (level > 255) return 8'd255;
    return 8'(level);
  endfunction

  // Wrap once the next value would reach the pitch; a zero pitch holds at 0.
  function automatic logic [7:0] step_phase(logic [7:0] phase);
    if (int'(phase) + 1 >= int'(pitch)) return 8'd0;
    return phase + 8'd1;
  endfunction

  function automatic void start_frame();
    lcg_word  = seed;
    col_pos   = 0;
    row_pos   = 0;
    col_phase = 8'd0;
    row_phase = 8'd0;
  endfunction

  function automatic pixel_t shade_next_pixel(logic rs);
    pixel_t      px;
    int          offset;
    logic [7:0]  span;
    logic [14:0] sample;
    if (rs) start_frame();
    offset = 0;
    if (amplitude != 0) begin
      span     = {amplitude, 1'b1};
      lcg_word = lcg_word * LCG_MULT + LCG_INCR;
      sample   = lcg_word[30:16];
      offset   = int'(sample % span) - int'(amplitude);
    end
    if (pitch != 0 && (col_phase < 2 || row_phase < 2)) offset -= GRID_DROP;
    px.red        = saturate(int'(base_r) + offset);
    px.green      = saturate(int'(base_g) + offset);
    px.blue       = saturate(int'(base_b) + offset);
    px.column     = 7'(col_pos);
    px.row        = 7'(row_pos);
    px.frame_last = (col_pos == IMAGE_SIDE - 1) && (row_pos == IMAGE_SIDE - 1);
    if (px.frame_last) begin
      start_frame();
    end else if (col_pos == IMAGE_SIDE - 1) begin
      col_pos   = 0;
      col_phase = 8'd0;
      row_pos++;
      row_phase = step_phase(row_phase);
    end else begin
      col_pos++;
      col_phase = step_phase(col_phase);
    end
    return px;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      base_r    = 8'd0;
      base_g    = 8'd0;
      base_b    = 8'd0;
      amplitude = 7'd0;
      pitch     = 8'd0;
      seed      = 32'd0;
      start_frame();
      pixels_due.delete();
    end else begin
      // Retire before predicting so a word never matches its own request.
      if (pix_valid && !pix_stall) begin
        pixels_checked++;
        if (frame_last) frames_seen++;
        if (pixels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_CAP)
            $display("%0t: pixel word at column %0d row %0d with none expected, got rgb %0d %0d %0d",
                     $time, column, row, red, green, blue);
        end else begin
          want = pixels_due.pop_front();
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          check_field("column", want.column, column);
          check_field("row", want.row, row);
          check_field("frame_last", want.frame_last, frame_last);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_BASE_RED:        base_r    = cfg_data[7:0];
          REG_BASE_GREEN:      base_g    = cfg_data[7:0];
          REG_BASE_BLUE:       base_b    = cfg_data[7:0];
          REG_NOISE_AMPLITUDE: amplitude = cfg_data[6:0];
          REG_GRID_PITCH:      pitch     = cfg_data[7:0];
          REG_NOISE_SEED:      seed      = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) pixels_due.push_back(shade_next_pixel(restart));
    end
    pixels_pending <= pixels_due.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the noise grid texture generator: clock, reset, register
// setup, request and stall stimulus, verdict.
// Depends on ngt_pkg, noise_grid_texture_generator_top and ngt_checker.
module tb;
  import ngt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int DRAIN_TAIL   = 14;
  localparam int HOLD_CYCLES  = 300;
  localparam int CHUNK_ITEMS  = 18;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 req_valid;
  logic                 req_stall;
  logic                 restart;
  logic                 pix_valid;
  logic                 pix_stall;
  logic [7:0]           red, green, blue;
  logic [6:0]           column, row;
  logic                 frame_last;

  int mismatches, pixels_pending, pixels_checked, frames_seen;
  int req_idle_pct, pix_stall_pct, phases_run;
  bit hold_off_req, hold_off_done;

  noise_grid_texture_generator_top dut (.*);
  ngt_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short bursts, now and then a long one.
  function automatic int burst_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Fill the bits above the register width with noise.
  function automatic logic [31:0] with_junk(logic [31:0] level, int width);
    return ($urandom() << width) | level;
  endfunction

  function automatic logic [31:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return with_junk(32'd0, 8);
    if (r < 4) return with_junk(32'd255, 8);
    return $urandom();
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_texture(input logic [31:0] r, g, b, amp, pitch_v, seed_v);
    write_reg(REG_BASE_RED, r);
    write_reg(REG_BASE_GREEN, g);
    write_reg(REG_BASE_BLUE, b);
    write_reg(REG_NOISE_AMPLITUDE, amp);
    write_reg(REG_GRID_PITCH, pitch_v);
    write_reg(REG_NOISE_SEED, seed_v);
  endtask

  task automatic pick_texture();
    logic [31:0] amp, pitch_v;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) amp = with_junk(32'd0, 7);
    else if (r < 4) amp = with_junk(32'd127, 7);
    else amp = $urandom();
    case ($urandom_range(0, 9))
      0:       pitch_v = with_junk(32'd0, 8);
      1:       pitch_v = with_junk(32'd1, 8);
      2:       pitch_v = with_junk(32'd2, 8);
      3:       pitch_v = with_junk(32'd128, 8);
      4:       pitch_v = with_junk(32'd255, 8);
      default: pitch_v = with_junk($urandom_range(3, 24), 8);
    endcase
    set_texture(pick_level(), pick_level(), pick_level(), amp, pitch_v, $urandom());
  endtask

  // Offer one request word and hold it until accepted.
  task automatic send_req(input logic rs);
    int gap;
    gap = ($urandom_range(0, 99) < req_idle_pct) ? burst_len() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      restart   <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    restart   <= rs;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic run_requests(input int count, input int restart_pct, input bit lead_restart);
    if (lead_restart) send_req(1'b1);
    repeat (count) send_req($urandom_range(0, 99) < restart_pct);
  endtask

  // Drop valid, wait out every pending pixel, then let the pipeline empty.
  task automatic drain_pixels();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    bit stall_now;
    pix_stall <= 1'b0;
    forever begin
      if (hold_off_req && !hold_off_done) begin
        pix_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        stall_now = ($urandom_range(0, 99) < pix_stall_pct);
        pix_stall <= stall_now;
        repeat (burst_len()) @(posedge clk);
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    req_valid <= 1'b0;
    restart   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: black texture, generator held.
    send_req(1'b0);
    send_req(1'b1);
    drain_pixels();

    // Full white with peak noise: saturation at the top.
    set_texture(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hA5A5_A5FF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    run_requests(2, 0, 1'b1);
    drain_pixels();

    // Black with peak noise and a tight grid: saturation at the bottom.
    set_texture(32'h0, 32'hFFFF_FF00, 32'h0, 32'h0000_007F, 32'hFFFF_FF02, 32'h0);
    run_requests(2, 0, 1'b1);
    drain_pixels();

    // No noise, pitch above the side; spare indexes must be ignored.
    set_texture(32'h0000_0080, 32'h0000_0040, 32'h0000_00C8, 32'hFFFF_FF80, 32'h0000_00FF,
                32'h1234_5678);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    run_requests(2, 0, 1'b1);
    drain_pixels();

    // Unit pitch darkens everything; a new seed waits for the next restart.
    write_reg(REG_NOISE_AMPLITUDE, 32'h1);
    write_reg(REG_GRID_PITCH, 32'h1);
    run_requests(2, 0, 1'b0);
    drain_pixels();
    write_reg(REG_NOISE_SEED, 32'hDEAD_BEEF);
    run_requests(2, 0, 1'b0);
    run_requests(0, 0, 1'b1);
    drain_pixels();

    // Pitch at the side length, mid amplitude.
    set_texture(32'h64, 32'h96, 32'h32, 32'h40, 32'h80, 32'h0BAD_F00D);
    run_requests(2, 0, 1'b1);
    drain_pixels();

    // Random phases; some continue the frame with the pitch changed under it.
    for (int p = 0; p < 12; p++) begin
      pick_texture();
      req_idle_pct  = pick_pct();
      pix_stall_pct = pick_pct();
      if (p == 2) begin
        // Sender keeps offering while the receiver holds off.
        req_idle_pct = 0;
        hold_off_req = 1'b1;
      end
      run_requests(150, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6),
                   1'($urandom_range(0, 1)));
      drain_pixels();
      phases_run++;
    end

    // Short chunks of one frame, reconfigured between them.
    req_idle_pct  = 10;
    pix_stall_pct = 10;
    pick_texture();
    run_requests(0, 0, 1'b1);
    for (int chunk = 0; chunk < 4; chunk++) begin
      run_requests(CHUNK_ITEMS, 0, 1'b0);
      drain_pixels();
      pick_texture();
      phases_run++;
    end

    $display("summary: %0d pixels checked, %0d frame ends, %0d random phases",
             pixels_checked, frames_seen, phases_run);
    $display("summary: color and amplitude extremes, pitch 0..255, restarts, mid-frame seed");
    if (mismatches == 0) begin
      $display("[noise_grid_texture_generator_top] OK");
    end else begin
      $display("[noise_grid_texture_generator_top] ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("[noise_grid_texture_generator_top] ERROR");
    $finish;
  end

endmodule
